>>> rtl/stepper_bin_positioner_core_macros.svh
// Assertion macros for the stepper bin positioner core.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef STEPPER_BIN_POSITIONER_CORE_MACROS_SVH
`define STEPPER_BIN_POSITIONER_CORE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SBP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sbp_pkg.sv
// Shared types, codes and coil table for the stepper bin positioner.
// No dependencies.
package sbp_pkg;

    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_MOVE = 2'd1;
    localparam logic [1:0] FUNC_HOME = 2'd2;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_HOME = 2'd1;
    localparam logic [1:0] MODE_MOVE = 2'd2;

    localparam logic [1:0] REG_SLOW_DELAY  = 2'd0;
    localparam logic [1:0] REG_FAST_DELAY  = 2'd1;
    localparam logic [1:0] REG_ACCEL_STEP  = 2'd2;
    localparam logic [1:0] REG_QUARTER_STEPS = 2'd3;

    localparam logic [7:0] SLOW_DELAY_RST = 8'd20;
    localparam logic [7:0] FAST_DELAY_RST = 8'd12;
    localparam logic [6:0] ACCEL_STEP_RST = 7'd15;
    localparam logic [6:0] QUARTER_RST    = 7'd50;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef struct packed {
        logic [1:0] func;
        logic [1:0] target_bin;
        logic       home_sensor;
    } in_t;

    typedef struct packed {
        logic [5:0] coil_pattern;
        logic [2:0] phase;
        logic [1:0] bin_position;
        logic       busy_res;
        logic       done_res;
        logic       rejected;
    } res_t;

    typedef struct packed {
        logic [7:0] slow_delay;
        logic [7:0] fast_delay;
        logic [6:0] accel_step;
        logic [6:0] quarter_turn_steps;
    } cfg_t;

    function automatic logic [5:0] coil_of(input logic [2:0] p);
        logic [5:0] c;
        case (p)
            3'd1:    c = 6'b110000;
            3'd2:    c = 6'b000110;
            3'd3:    c = 6'b101000;
            3'd4:    c = 6'b000101;
            default: c = 6'b000000;
        endcase
        return c;
    endfunction

    // Phase sequence 1..4 wrapping; stepping back from 0 or 1 lands on 4.
    function automatic logic [2:0] next_phase(input logic [2:0] p, input logic back);
        logic [2:0] q;
        q = (p > 3'd4) ? 3'd0 : p;
        if (back)
            return (q <= 3'd1) ? 3'd4 : q - 3'd1;
        else
            return (q >= 3'd4) ? 3'd1 : q + 3'd1;
    endfunction

endpackage

>>> rtl/sbp_cfg_regs.sv
// APB configuration registers for the stepper bin positioner.
// Depends on sbp_pkg.
module sbp_cfg_regs
    import sbp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slow_delay         <= SLOW_DELAY_RST;
            cfg_reg.fast_delay         <= FAST_DELAY_RST;
            cfg_reg.accel_step         <= ACCEL_STEP_RST;
            cfg_reg.quarter_turn_steps <= QUARTER_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SLOW_DELAY:    cfg_reg.slow_delay         <= pwdata[7:0];
                REG_FAST_DELAY:    cfg_reg.fast_delay         <= pwdata[7:0];
                REG_ACCEL_STEP:    cfg_reg.accel_step         <= pwdata[6:0];
                REG_QUARTER_STEPS: cfg_reg.quarter_turn_steps <= pwdata[6:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SLOW_DELAY:    prdata = {24'd0, cfg_reg.slow_delay};
            REG_FAST_DELAY:    prdata = {24'd0, cfg_reg.fast_delay};
            REG_ACCEL_STEP:    prdata = {25'd0, cfg_reg.accel_step};
            REG_QUARTER_STEPS: prdata = {25'd0, cfg_reg.quarter_turn_steps};
            default:           prdata = '0;
        endcase
    end

endmodule

>>> rtl/sbp_step_core.sv
// Motion state and per-request update logic: homing, moves, step timing.
// Depends on sbp_pkg.
module sbp_step_core
    import sbp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  in_t  req,
    input  cfg_t cfg,
    output res_t res
);

    logic [2:0] phase_reg,  phase_next;
    logic [1:0] bin_reg,    bin_next;
    logic [1:0] mode_reg,   mode_next;
    logic [7:0] total_reg,  total_next;
    logic [7:0] index_reg,  index_next;
    logic [7:0] tick_reg,   tick_next;
    logic       fast_reg,   fast_next;
    logic       rev_reg,    rev_next;
    logic       latch_reg,  latch_next;

    logic       busy;
    logic       done;
    logic       rej;
    logic [1:0] diff;
    logic       rev_new;
    logic [7:0] total_new;
    logic [7:0] delay_raw;
    logic [7:0] delay;
    logic [7:0] tick_inc;
    logic       latch_now;
    logic [2:0] phase_out;

    assign busy = (mode_reg != MODE_IDLE);

    always_comb
    begin
        phase_next = phase_reg;
        bin_next   = bin_reg;
        mode_next  = mode_reg;
        total_next = total_reg;
        index_next = index_reg;
        tick_next  = tick_reg;
        fast_next  = fast_reg;
        rev_next   = rev_reg;
        latch_next = latch_reg;
        done       = 1'b0;
        rej        = 1'b0;

        diff      = req.target_bin - bin_reg;
        rev_new   = (diff == 2'd3);
        total_new = (diff == 2'd2) ? {cfg.quarter_turn_steps, 1'b0}
                                   : {1'b0, cfg.quarter_turn_steps};

        if (mode_reg == MODE_HOME)
            delay_raw = cfg.slow_delay;
        else
            delay_raw = fast_reg ? cfg.fast_delay : cfg.slow_delay;
        delay     = (delay_raw == 8'd0) ? 8'd1 : delay_raw;
        tick_inc  = (tick_reg == 8'hFF) ? 8'hFF : tick_reg + 8'd1;
        latch_now = latch_reg | req.home_sensor;

        if (req.func == FUNC_MOVE || req.func == FUNC_HOME)
        begin
            if (busy)
                rej = 1'b1;
            else if (req.func == FUNC_HOME)
            begin
                mode_next  = MODE_HOME;
                latch_next = 1'b0;
                phase_next = 3'd1;
                tick_next  = 8'd0;
            end
            else
            begin
                bin_next = req.target_bin;
                if (diff == 2'd0)
                    done = 1'b1;
                else
                begin
                    rev_next   = rev_new;
                    total_next = total_new;
                    if (total_new == 8'd0)
                        done = 1'b1;
                    else
                    begin
                        mode_next  = MODE_MOVE;
                        fast_next  = 1'b0;
                        phase_next = next_phase(phase_reg, rev_new);
                        index_next = 8'd1;
                        tick_next  = 8'd0;
                    end
                end
            end
        end
        else if (req.func == FUNC_TICK && busy)
        begin
            if (mode_reg == MODE_HOME)
                latch_next = latch_now;
            tick_next = tick_inc;
            if (tick_inc >= delay)
            begin
                tick_next = 8'd0;
                if (mode_reg == MODE_HOME)
                begin
                    if (latch_now)
                    begin
                        mode_next = MODE_IDLE;
                        bin_next  = 2'd0;
                        done      = 1'b1;
                    end
                    else
                        phase_next = next_phase(phase_reg, 1'b0);
                end
                else
                begin
                    if (index_reg > {1'b0, cfg.accel_step})
                        fast_next = 1'b1;
                    if (index_reg >= total_reg)
                    begin
                        mode_next = MODE_IDLE;
                        done      = 1'b1;
                    end
                    else
                    begin
                        phase_next = next_phase(phase_reg, rev_reg);
                        index_next = index_reg + 8'd1;
                    end
                end
            end
        end

        phase_out        = (phase_next <= 3'd4) ? phase_next : 3'd0;
        res.coil_pattern = coil_of(phase_out);
        res.phase        = phase_out;
        res.bin_position = bin_next;
        res.busy_res     = (mode_next != MODE_IDLE);
        res.done_res     = done;
        res.rejected     = rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 3'd0;
            bin_reg   <= 2'd0;
            mode_reg  <= MODE_IDLE;
            total_reg <= 8'd0;
            index_reg <= 8'd0;
            tick_reg  <= 8'd0;
            fast_reg  <= 1'b0;
            rev_reg   <= 1'b0;
            latch_reg <= 1'b0;
        end
        else if (adv)
        begin
            phase_reg <= phase_next;
            bin_reg   <= bin_next;
            mode_reg  <= mode_next;
            total_reg <= total_next;
            index_reg <= index_next;
            tick_reg  <= tick_next;
            fast_reg  <= fast_next;
            rev_reg   <= rev_next;
            latch_reg <= latch_next;
        end
    end

endmodule

>>> rtl/stepper_bin_positioner_core.sv
// Stepper bin positioner: a request accepted into the input register moves into
// the result register when the result side can take it; out_valid then shows it.
// Throughput one request per cycle while the result side keeps up; out_stall
// holds the result register and reaches in_stall in the same cycle.
// Input register feeds the step core; its update lands in the result register.
// Reset: rst_n asynchronous low; state and valid registers go to defaults, idle, phase 0.
`include "stepper_bin_positioner_core_macros.svh"
module stepper_bin_positioner_core
    import sbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              in_valid,
    output logic              in_stall,
    input  in_t               in_req,
    // result channel
    output logic              out_valid,
    input  logic              out_stall,
    output res_t              out_res,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t cfg;
    in_t  s1_req_reg;
    logic s1_valid_reg;
    logic s1_adv;
    logic in_take;
    res_t res_next;
    res_t res_reg;
    logic out_valid_reg;

    sbp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Advance the held request into the core whenever the result register
    // is empty or is being drained this cycle.
    assign s1_adv   = s1_valid_reg & (~out_valid_reg | ~out_stall);
    // Stall new requests only while a held request cannot move on.
    assign in_stall = s1_valid_reg & ~s1_adv;
    assign in_take  = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_req_reg <= in_req;
    end

    sbp_step_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (s1_adv),
        .req   (s1_req_reg),
        .cfg   (cfg),
        .res   (res_next)
    );

    // Result register: load on advance, drop once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= 1'b1;
        else if (~out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    `SBP_ASSERT_SAME(a_stall_needs_held, in_stall, s1_valid_reg, "stall without held request")
    `SBP_ASSERT_NEXT(a_adv_fills_out, s1_adv, out_valid_reg, "advance did not fill result")
    `SBP_ASSERT_SAME(a_done_not_rej, out_valid_reg, !(res_reg.done_res && res_reg.rejected), "done and rejected together")

endmodule

>>> tb/tb_stepper_bin_positioner_core.sv
// Self-checking testbench for stepper_bin_positioner_core: directed and random
// requests, APB register writes, random idling on both channels. Needs sbp_pkg.
`timescale 1ns / 1ps

module tb_stepper_bin_positioner_core;
    import sbp_pkg::*;

    // func code 3 has no meaning; the block must leave its state alone and not reject it
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 70;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int REPORT_MAX   = 10;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    in_t               in_req = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    res_t              out_res;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    stepper_bin_positioner_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_req   (in_req),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_res  (out_res),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Requests waiting to be driven, and results owed by the block, oldest first.
    in_t  pending_reqs[$];
    res_t expected_results[$];

    int   fault_count = 0;
    int   cycle_count = 0;
    int   src_gap = 0;
    int   sink_hold = 0;
    bit   calm_tail = 1'b0;
    bit   req_taken;
    res_t next_result;

    // Register copy, updated right after each APB write lands.
    cfg_t cfg = '{SLOW_DELAY_RST, FAST_DELAY_RST, ACCEL_STEP_RST, QUARTER_RST};

    // Positioner state as seen from outside.
    logic [1:0] pos_mode    = MODE_IDLE;
    logic [2:0] pos_phase   = 3'd0;
    logic [1:0] pos_bin     = 2'd0;
    logic [7:0] step_total  = 8'd0;
    logic [7:0] step_index  = 8'd0;
    logic [7:0] tick_count  = 8'd0;
    logic       use_fast    = 1'b0;
    logic       reverse_dir = 1'b0;
    logic       home_latch  = 1'b0;

    function automatic logic [5:0] coil_bits(input logic [2:0] p);
        case (p)
            3'd1:    return 6'b110000;
            3'd2:    return 6'b000110;
            3'd3:    return 6'b101000;
            3'd4:    return 6'b000101;
            default: return 6'b000000;
        endcase
    endfunction

    // Forward runs 1,2,3,4,1...; backward runs 4,3,2,1,4... and 0 goes to 4.
    function automatic logic [2:0] phase_after(input logic [2:0] p, input logic back);
        logic [2:0] cur;
        cur = (p > 3'd4) ? 3'd0 : p;
        if (back)
            return (cur <= 3'd1) ? 3'd4 : cur - 3'd1;
        return (cur == 3'd4) ? 3'd1 : cur + 3'd1;
    endfunction

    // Apply one accepted request to the state copy and form the result it owes.
    task automatic advance_positioner(input in_t rq, output res_t rs);
        logic [1:0] diff;
        logic [7:0] dly;
        logic       done;
        logic       rej;
        logic       busy;
        done = 1'b0;
        rej  = 1'b0;
        busy = (pos_mode != MODE_IDLE);
        if (rq.func == FUNC_MOVE || rq.func == FUNC_HOME)
        begin
            if (busy)
                rej = 1'b1;
            else if (rq.func == FUNC_HOME)
            begin
                pos_mode   = MODE_HOME;
                home_latch = 1'b0;
                pos_phase  = 3'd1;
                tick_count = 8'd0;
            end
            else
            begin
                diff    = rq.target_bin - pos_bin;
                pos_bin = rq.target_bin;
                if (diff == 2'd0)
                    done = 1'b1;
                else
                begin
                    reverse_dir = (diff == 2'd3);
                    step_total  = (diff == 2'd2) ? {cfg.quarter_turn_steps, 1'b0}
                                                 : {1'b0, cfg.quarter_turn_steps};
                    if (step_total == 8'd0)
                        done = 1'b1;
                    else
                    begin
                        pos_mode   = MODE_MOVE;
                        use_fast   = 1'b0;
                        pos_phase  = phase_after(pos_phase, reverse_dir);
                        step_index = 8'd1;
                        tick_count = 8'd0;
                    end
                end
            end
        end
        else if (rq.func == FUNC_TICK && busy)
        begin
            if (pos_mode == MODE_HOME)
            begin
                if (rq.home_sensor)
                    home_latch = 1'b1;
                dly = cfg.slow_delay;
            end
            else
                dly = use_fast ? cfg.fast_delay : cfg.slow_delay;
            if (dly == 8'd0)
                dly = 8'd1;
            if (tick_count != 8'hFF)
                tick_count = tick_count + 8'd1;
            if (tick_count >= dly)
            begin
                tick_count = 8'd0;
                if (pos_mode == MODE_HOME)
                begin
                    if (home_latch)
                    begin
                        pos_mode = MODE_IDLE;
                        pos_bin  = 2'd0;
                        done     = 1'b1;
                    end
                    else
                        pos_phase = phase_after(pos_phase, 1'b0);
                end
                else
                begin
                    if (step_index > {1'b0, cfg.accel_step})
                        use_fast = 1'b1;
                    if (step_index >= step_total)
                    begin
                        pos_mode = MODE_IDLE;
                        done     = 1'b1;
                    end
                    else
                    begin
                        pos_phase  = phase_after(pos_phase, reverse_dir);
                        step_index = step_index + 8'd1;
                    end
                end
            end
        end
        rs.coil_pattern = coil_bits(pos_phase);
        rs.phase        = (pos_phase <= 3'd4) ? pos_phase : 3'd0;
        rs.bin_position = pos_bin;
        rs.busy_res     = (pos_mode != MODE_IDLE);
        rs.done_res     = done;
        rs.rejected     = rej;
    endtask

    // Compare one result with the oldest one owed; report the first few misses.
    task automatic check_result(input res_t got);
        res_t want;
        if (expected_results.size() == 0)
        begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
                $display("ERROR: result with nothing owed: %p", got);
        end
        else
        begin
            want = expected_results.pop_front();
            if (got.coil_pattern !== want.coil_pattern || got.phase !== want.phase ||
                got.bin_position !== want.bin_position || got.busy_res !== want.busy_res ||
                got.done_res !== want.done_res || got.rejected !== want.rejected)
            begin
                fault_count++;
                if (fault_count <= REPORT_MAX)
                    $display("ERROR: expected %p, actual %p", want, got);
            end
        end
    endtask

    // Request driver: predict on each accept, then present the next request
    // unless a random gap is running.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            req_taken = in_valid && !in_stall;
            if (req_taken)
            begin
                advance_positioner(in_req, next_result);
                expected_results.push_back(next_result);
            end
            if (!in_valid || req_taken)
            begin
                if (src_gap != 0)
                begin
                    src_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_req   <= pending_reqs.pop_front();
                    if (!calm_tail && $urandom_range(0, 7) == 0)
                        src_gap = $urandom_range(1, 6);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: check each accepted result, stall in random bursts.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            sink_hold = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result(out_res);
            if (sink_hold != 0)
            begin
                sink_hold--;
                out_stall <= 1'b1;
            end
            else if (!calm_tail && $urandom_range(0, 7) == 0)
            begin
                sink_hold = $urandom_range(0, 5);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: stop a run that hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic queue_req(input logic [1:0] f, input logic [1:0] tgt, input logic sensor);
        in_t rq;
        rq.func        = f;
        rq.target_bin  = tgt;
        rq.home_sensor = sensor;
        pending_reqs.push_back(rq);
    endtask

    task automatic queue_tick(input logic sensor);
        queue_req(FUNC_TICK, 2'($urandom_range(0, 3)), sensor);
    endtask

    // Move request plus enough ticks to finish the longest move; a broken one
    // cuts the ticks short. Stray commands that land mid-move must be rejected.
    task automatic queue_move(input logic [1:0] tgt, input bit broken);
        int n;
        int slow_e;
        int fast_e;
        slow_e = (cfg.slow_delay == 8'd0) ? 1 : int'(cfg.slow_delay);
        fast_e = (cfg.fast_delay == 8'd0) ? 1 : int'(cfg.fast_delay);
        n = 2 * cfg.quarter_turn_steps * ((slow_e > fast_e) ? slow_e : fast_e) + 4;
        if (broken)
            n = $urandom_range(0, n);
        queue_req(FUNC_MOVE, tgt, 1'($urandom_range(0, 1)));
        repeat (n)
        begin
            if ($urandom_range(0, 24) == 0)
                queue_req(2'($urandom_range(1, 2)), 2'($urandom_range(0, 3)),
                          1'($urandom_range(0, 1)));
            else
                queue_tick(1'($urandom_range(0, 1)));
        end
    endtask

    // Homing request, a quiet stretch, a sensor hit, then enough ticks to
    // reach the next step boundary.
    task automatic queue_homing();
        int slow_e;
        slow_e = (cfg.slow_delay == 8'd0) ? 1 : int'(cfg.slow_delay);
        queue_req(FUNC_HOME, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 3 * slow_e))
            queue_tick(1'b0);
        queue_tick(1'b1);
        repeat (slow_e + 1)
            queue_tick(1'($urandom_range(0, 1)));
    endtask

    // Hold until every request has gone in and every result has come back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        case (idx)
            REG_SLOW_DELAY:    cfg.slow_delay = val;
            REG_FAST_DELAY:    cfg.fast_delay = val;
            REG_ACCEL_STEP:    cfg.accel_step = val[6:0];
            REG_QUARTER_STEPS: cfg.quarter_turn_steps = val[6:0];
            default: ;
        endcase
    endtask

    // Drain, let the pipeline settle, then write all four registers.
    task automatic apply_setting(input logic [7:0] slow, input logic [7:0] fast,
                                 input logic [7:0] accel, input logic [7:0] quarter);
        wait_drained();
        repeat (4)
            @(negedge clk);
        write_reg(REG_SLOW_DELAY, slow);
        write_reg(REG_FAST_DELAY, fast);
        write_reg(REG_ACCEL_STEP, accel);
        write_reg(REG_QUARTER_STEPS, quarter);
    endtask

    initial
    begin
        int         ph;
        int         mark;
        int         pick;
        logic [4:0] raw;
        logic [7:0] slow;
        logic [7:0] fast;
        logic [7:0] accel;
        logic [7:0] quarter;

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: unused func, idle tick, move to the bin already held.
        queue_req(FUNC_UNUSED, 2'd3, 1'b1);
        queue_tick(1'b1);
        queue_req(FUNC_MOVE, 2'd0, 1'b0);

        // One-step quarter turn: a reverse move from phase zero lands on 4,
        // commands mid-move are rejected, then homing and a half turn.
        apply_setting(8'd1, 8'd1, 8'd0, 8'd1);
        queue_req(FUNC_MOVE, 2'd3, 1'b0);
        queue_req(FUNC_MOVE, 2'd1, 1'b1);
        queue_req(FUNC_HOME, 2'd2, 1'b0);
        queue_tick(1'b0);
        queue_req(FUNC_HOME, 2'd0, 1'b0);
        queue_tick(1'b0);
        queue_tick(1'b1);
        queue_req(FUNC_MOVE, 2'd2, 1'b1);
        queue_tick(1'b0);
        queue_tick(1'b1);

        // Zero step count and zero delays.
        apply_setting(8'd0, 8'd0, 8'd0, 8'd0);
        queue_req(FUNC_MOVE, 2'd1, 1'b0);
        queue_req(FUNC_HOME, 2'd1, 1'b0);
        queue_tick(1'b1);

        // Largest values; leave homing running into the next setting.
        apply_setting(8'd255, 8'd255, 8'd127, 8'd127);
        queue_req(FUNC_HOME, 2'd0, 1'b1);
        queue_tick(1'b1);
        queue_tick(1'b0);
        queue_req(FUNC_MOVE, 2'd3, 1'b0);

        // Random phases: mostly complete move and homing sequences.
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph == RAND_PHASES - 1)
                calm_tail = 1'b1;
            if (ph % 3 == 2)
            begin
                slow    = 8'($urandom_range(1, 2));
                fast    = 8'($urandom_range(0, 1));
                accel   = 8'($urandom_range(0, 40));
                quarter = 8'($urandom_range(10, 30));
            end
            else
            begin
                slow    = 8'($urandom_range(0, 4));
                fast    = 8'($urandom_range(0, 3));
                accel   = 8'($urandom_range(0, 6));
                quarter = 8'($urandom_range(0, 6));
            end
            apply_setting(slow, fast, accel, quarter);
            mark = pending_reqs.size();
            while (pending_reqs.size() - mark < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    queue_move(2'($urandom_range(0, 3)), $urandom_range(0, 9) == 0);
                else if (pick < 75)
                    queue_homing();
                else if (pick < 85)
                    repeat ($urandom_range(1, 5))
                        queue_tick(1'($urandom_range(0, 1)));
                else if (pick < 92)
                    queue_req(FUNC_UNUSED, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
                else
                begin
                    raw = 5'($urandom_range(0, 31));
                    pending_reqs.push_back(in_t'(raw));
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        if (fault_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/sbp_pkg.sv
rtl/sbp_cfg_regs.sv
rtl/sbp_step_core.sv
rtl/stepper_bin_positioner_core.sv
tb/tb_stepper_bin_positioner_core.sv
